@@ sv/gbs_pkg.sv @@
// Shared types and constants for the greedy box suppression block.
// No dependencies; every other file uses these by scoped names.
package gbs_pkg;

    localparam int COORD_W   = 16;
    localparam int AREA_W    = 32;
    localparam int THR_W     = 9;
    localparam int COUNT_W   = 7;
    localparam int INDEX_W   = 16;
    localparam int UNI_W     = AREA_W + 1;
    localparam int LHS_W     = AREA_W + 8;
    localparam int PROD_W    = UNI_W + THR_W;

    localparam int MAX_KEPT_DEF = 64;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(115);

    // Register map, word index
    localparam logic REG_IOU_THRESHOLD = 1'b0;

    typedef struct packed {
        logic [COORD_W-1:0] box_left;
        logic [COORD_W-1:0] box_top;
        logic [COORD_W-1:0] box_width;
        logic [COORD_W-1:0] box_height;
        logic               first_of_set;
    } box_t;

    typedef struct packed {
        logic               kept;
        logic [INDEX_W-1:0] box_index;
        logic [COUNT_W-1:0] kept_count;
        logic               overflow;
    } result_t;

    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
    } corners_t;

    typedef struct packed {
        logic valid;     // one comparison finished this cycle
        logic suppress;  // that comparison suppresses the new box
        logic active;    // comparisons still in flight
    } judge_status_t;

endpackage

@@ sv/gbs_store.sv @@
// Kept-box store: corner and area memories, one write and one read port each.
// Depends on gbs_pkg for corners_t and field widths.
module gbs_store #(
    parameter int MAX_KEPT = gbs_pkg::MAX_KEPT_DEF,
    parameter int AW       = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  gbs_pkg::corners_t             wr_corners,
    input  logic [gbs_pkg::AREA_W-1:0]    wr_area,
    input  logic                          rd_en,
    input  logic [AW-1:0]                 rd_addr,
    output gbs_pkg::corners_t             rd_corners,
    output logic [gbs_pkg::AREA_W-1:0]    rd_area,
    output logic                          rd_valid
);

    gbs_pkg::corners_t               corner_mem [MAX_KEPT];
    logic [gbs_pkg::AREA_W-1:0]      area_mem   [MAX_KEPT];
    gbs_pkg::corners_t               rd_corners_reg;
    logic [gbs_pkg::AREA_W-1:0]      rd_area_reg;
    logic                            rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            corner_mem[wr_addr] <= wr_corners;
            area_mem[wr_addr]   <= wr_area;
        end
        if (rd_en)
        begin
            rd_corners_reg <= corner_mem[rd_addr];
            rd_area_reg    <= area_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_valid_reg <= 1'b0;
        else
            rd_valid_reg <= rd_en;
    end

    assign rd_corners = rd_corners_reg;
    assign rd_area    = rd_area_reg;
    assign rd_valid   = rd_valid_reg;

endmodule

@@ sv/gbs_judge.sv @@
// Pipelined overlap test of the new box against one stored box per cycle:
// intersection, union, then inter*256 > threshold*union. Depends on gbs_pkg.
module gbs_judge (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  gbs_pkg::corners_t             kept_box,
    input  logic [gbs_pkg::AREA_W-1:0]    kept_area,
    input  gbs_pkg::corners_t             new_box,
    input  logic [gbs_pkg::AREA_W-1:0]    new_area,
    input  logic [gbs_pkg::THR_W-1:0]     threshold,
    output gbs_pkg::judge_status_t        status
);

    localparam int CW = gbs_pkg::COORD_W;

    logic [CW-1:0] x0, x1, y0, y1;
    logic          overlaps;

    logic                          s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic                          s1_ov_reg;
    logic [CW-1:0]                 s1_dx_reg, s1_dy_reg;
    logic [gbs_pkg::AREA_W-1:0]    s1_karea_reg;
    logic [gbs_pkg::AREA_W-1:0]    s2_inter_reg;
    logic [gbs_pkg::UNI_W-1:0]     s2_sum_reg;
    logic [gbs_pkg::AREA_W-1:0]    s3_inter_reg;
    logic [gbs_pkg::UNI_W-1:0]     s3_uni_reg;
    logic [gbs_pkg::LHS_W-1:0]     s4_lhs_reg;
    logic [gbs_pkg::PROD_W-1:0]    s4_prod_reg;

    always_comb
    begin
        x0 = (new_box.left  > kept_box.left)   ? new_box.left   : kept_box.left;
        x1 = (new_box.right < kept_box.right)  ? new_box.right  : kept_box.right;
        y0 = (new_box.top   > kept_box.top)    ? new_box.top    : kept_box.top;
        y1 = (new_box.bottom < kept_box.bottom) ? new_box.bottom : kept_box.bottom;
        // touching edges count as no overlap
        overlaps = (x1 > x0) && (y1 > y0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ov_reg    <= overlaps;
        s1_dx_reg    <= x1 - x0;
        s1_dy_reg    <= y1 - y0;
        s1_karea_reg <= kept_area;

        s2_inter_reg <= s1_ov_reg ? (gbs_pkg::AREA_W'(s1_dx_reg) * gbs_pkg::AREA_W'(s1_dy_reg))
                                  : '0;
        s2_sum_reg   <= gbs_pkg::UNI_W'(new_area) + gbs_pkg::UNI_W'(s1_karea_reg);

        s3_inter_reg <= s2_inter_reg;
        s3_uni_reg   <= s2_sum_reg - gbs_pkg::UNI_W'(s2_inter_reg);

        s4_lhs_reg   <= {s3_inter_reg, 8'b0};
        s4_prod_reg  <= gbs_pkg::PROD_W'(threshold) * gbs_pkg::PROD_W'(s3_uni_reg);
    end

    // zero union gives zero intersection, so the compare never fires there
    assign status.valid    = s4_vld_reg;
    assign status.suppress = s4_vld_reg && (gbs_pkg::PROD_W'(s4_lhs_reg) > s4_prod_reg);
    assign status.active   = in_valid || s1_vld_reg || s2_vld_reg || s3_vld_reg
                             || s4_vld_reg;

endmodule

@@ sv/greedy_box_suppression.sv @@
// Top level of the greedy box suppression block: sequencer, APB register,
// result register. Uses gbs_pkg, gbs_store and gbs_judge.
//
// A box is taken when start is high and busy is low. The current set holds
// at most MAX_KEPT stored boxes. ST_PREP forms the corners and ST_AREA the
// area. The scan then reads one stored box per cycle and, after the last
// read, moves to ST_DRAIN, which waits until the compare pipeline is empty.
// ST_DONE writes a kept box back when there is room, and the result register
// shows the verdict in the cycle after that. The result appears on result
// for one cycle with done high and must be taken then.
// busy drops in that same cycle, so the next box may start at once.
// The store needs no clearing after reset.
module greedy_box_suppression #(
    parameter int MAX_KEPT = gbs_pkg::MAX_KEPT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  gbs_pkg::box_t         box,
    output logic                  done,
    output gbs_pkg::result_t      result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int AW  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CNW = $clog2(MAX_KEPT + 1);
    localparam int CW  = gbs_pkg::COORD_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_AREA  = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]                 state_reg, state_next;
    logic [gbs_pkg::THR_W-1:0]  thr_reg;
    logic [CNW-1:0]             count_reg, count_next;
    logic [CNW-1:0]             rd_cnt_reg, rd_cnt_next;
    logic [gbs_pkg::INDEX_W-1:0] pos_reg, pos_next;
    logic [gbs_pkg::INDEX_W-1:0] index_reg, index_next;
    logic                       keep_reg, keep_next;
    logic                       done_reg, done_next;
    gbs_pkg::result_t           result_reg, result_next;
    gbs_pkg::box_t              in_reg;
    gbs_pkg::corners_t          box_reg;
    logic [gbs_pkg::AREA_W-1:0] area_reg;

    logic [CW:0]                right_sum, bottom_sum;
    logic                       accept;
    logic                       cfg_write;
    logic                       rd_en;
    logic                       wr_en;
    logic                       room;
    gbs_pkg::corners_t          rd_corners;
    logic [gbs_pkg::AREA_W-1:0] rd_area;
    logic                       rd_valid;
    gbs_pkg::judge_status_t     judge;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == gbs_pkg::REG_IOU_THRESHOLD) ? 32'(thr_reg) : 32'd0;
    assign room      = (count_reg < CNW'(MAX_KEPT));
    assign rd_en     = (state_reg == ST_SCAN) && (rd_cnt_reg < count_reg);
    assign wr_en     = (state_reg == ST_DONE) && keep_reg && room;
    assign done      = done_reg;
    assign result    = result_reg;

    assign right_sum  = {1'b0, in_reg.box_left} + {1'b0, in_reg.box_width};
    assign bottom_sum = {1'b0, in_reg.box_top}  + {1'b0, in_reg.box_height};

    gbs_store #(
        .MAX_KEPT (MAX_KEPT),
        .AW       (AW)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_addr    (count_reg[AW-1:0]),
        .wr_corners (box_reg),
        .wr_area    (area_reg),
        .rd_en      (rd_en),
        .rd_addr    (rd_cnt_reg[AW-1:0]),
        .rd_corners (rd_corners),
        .rd_area    (rd_area),
        .rd_valid   (rd_valid)
    );

    gbs_judge u_judge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rd_valid),
        .kept_box  (rd_corners),
        .kept_area (rd_area),
        .new_box   (box_reg),
        .new_area  (area_reg),
        .threshold (thr_reg),
        .status    (judge)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        rd_cnt_next = rd_cnt_reg;
        pos_next    = pos_reg;
        index_next  = index_reg;
        keep_next   = keep_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        if (judge.valid && judge.suppress)
            keep_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next  = ST_PREP;
                    rd_cnt_next = '0;
                    keep_next   = 1'b1;
                    if (box.first_of_set)
                    begin
                        count_next = '0;
                        index_next = '0;
                        pos_next   = gbs_pkg::INDEX_W'(1);
                    end
                    else
                    begin
                        index_next = pos_reg;
                        pos_next   = pos_reg + gbs_pkg::INDEX_W'(1);
                    end
                end
            end
            ST_PREP:
                state_next = ST_AREA;
            ST_AREA:
                state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (rd_cnt_reg < count_reg)
                    rd_cnt_next = rd_cnt_reg + CNW'(1);
                else
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!judge.active)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                if (keep_reg && room)
                    count_next = count_reg + CNW'(1);
                result_next.kept       = keep_reg;
                result_next.box_index  = index_reg;
                result_next.kept_count = (keep_reg && room)
                                         ? gbs_pkg::COUNT_W'(count_reg + CNW'(1))
                                         : gbs_pkg::COUNT_W'(count_reg);
                result_next.overflow   = keep_reg && !room;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            thr_reg    <= gbs_pkg::THR_RESET;
            count_reg  <= '0;
            rd_cnt_reg <= '0;
            pos_reg    <= '0;
            index_reg  <= '0;
            keep_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rd_cnt_reg <= rd_cnt_next;
            pos_reg    <= pos_next;
            index_reg  <= index_next;
            keep_reg   <= keep_next;
            done_reg   <= done_next;
            if (cfg_write && (paddr[2] == gbs_pkg::REG_IOU_THRESHOLD))
                thr_reg <= pwdata[gbs_pkg::THR_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (accept)
            in_reg <= box;
        if (state_reg == ST_PREP)
        begin
            box_reg.left   <= in_reg.box_left;
            box_reg.top    <= in_reg.box_top;
            box_reg.right  <= right_sum[CW] ? {CW{1'b1}} : right_sum[CW-1:0];
            box_reg.bottom <= bottom_sum[CW] ? {CW{1'b1}} : bottom_sum[CW-1:0];
        end
        if (state_reg == ST_AREA)
            area_reg <= gbs_pkg::AREA_W'(box_reg.right - box_reg.left)
                        * gbs_pkg::AREA_W'(box_reg.bottom - box_reg.top);
    end

endmodule
